[src/tssu_pkg.sv]
package tssu_pkg;

    // sizing of the task and semaphore tables
    localparam int NUM_TASKS   = 8;
    localparam int NUM_SEMS    = 8;
    localparam int MS_PER_TICK = 10;

    localparam int TASK_W  = $clog2(NUM_TASKS);
    localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int Q_DEPTH = NUM_SEMS * NUM_TASKS;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(NUM_TASKS + 1);
    localparam int TICK_W  = 32;
    localparam int VAL_W   = 9;

    // reciprocal for the milliseconds-to-ticks conversion
    localparam logic [63:0] RECIP64   = 64'h0000_0000_FFFF_FFFF / MS_PER_TICK;
    localparam logic [31:0] DIV_RECIP = RECIP64[31:0];

    // semaphore count bounds
    localparam logic signed [VAL_W-1:0] SEM_MIN = -9'sd256;
    localparam logic signed [VAL_W-1:0] SEM_MAX = 9'sd255;

    // request modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_SLEEP   = 3'd1;
    localparam logic [2:0] MODE_WAIT    = 3'd2;
    localparam logic [2:0] MODE_SIGNAL  = 3'd3;
    localparam logic [2:0] MODE_INIT    = 3'd4;
    localparam logic [2:0] MODE_RESCHED = 3'd5;

    typedef logic [TASK_W-1:0] t_task;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_RELEASE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_task                   head;
        t_task                   tail;
    } t_sem_entry;

    // commands to the task table
    typedef struct packed {
        logic              scan_start;
        logic              wake_we;
        logic              block_set;
        logic              block_clr;
        t_task             cur;
        t_task             clr_task;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] wake_data;
    } t_tt_cmd;

    // scan status from the task table
    typedef struct packed {
        logic  done;
        logic  found;
        t_task run_task;
    } t_tt_sts;

    // round-robin successor of a task index
    function automatic t_task next_task(input t_task t);
        t_task r;
        if (t == t_task'(NUM_TASKS - 1)) begin
            r = '0;
        end else begin
            r = t_task'(t + 1'b1);
        end
        return r;
    endfunction

endpackage

[src/tssu_req_if.sv]
interface tssu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  sem_index;
    logic [15:0] sleep_ms;
    logic [7:0]  init_value;

    modport source (output valid, mode, sem_index, sleep_ms, init_value, input ready);
    modport sink   (input valid, mode, sem_index, sleep_ms, init_value, output ready);
endinterface

[src/tssu_rsp_if.sv]
interface tssu_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        running_task;
    logic              no_ready;
    logic              caller_blocked;
    logic              released_valid;
    logic [2:0]        released_task;
    logic signed [8:0] sem_count;

    modport source (output valid, running_task, no_ready, caller_blocked, released_valid,
                    released_task, sem_count, input ready);
    modport sink   (input valid, running_task, no_ready, caller_blocked, released_valid,
                    released_task, sem_count, output ready);
endinterface

[src/tssu_task_table.sv]
module tssu_task_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tssu_pkg::t_tt_cmd i_cmd,
    output tssu_pkg::t_tt_sts o_sts
);
    import tssu_pkg::*;

    logic [TICK_W-1:0]    wake_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_wake_vld;
    logic [NUM_TASKS-1:0] r_blocked;

    logic              r_active;
    t_task             r_issue_t;
    logic [CNT_W-1:0]  r_issue_cnt;
    logic              r_chk_vld;
    logic              r_chk_last;
    t_task             r_chk_t;
    logic [TICK_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic              issue;
    logic [TICK_W-1:0] wake_eff;
    logic              hit;
    logic              done;

    // one read per cycle, check of the previous read in the same cycle
    assign issue    = r_active && (r_issue_cnt != CNT_W'(NUM_TASKS));
    assign wake_eff = r_rd_vld ? r_rd_data : '0;
    assign hit      = r_chk_vld && !r_blocked[r_chk_t] && (wake_eff <= i_cmd.tick);
    assign done     = hit || (r_chk_vld && r_chk_last);

    assign o_sts.done     = done;
    assign o_sts.found    = hit;
    assign o_sts.run_task = r_chk_t;

    // wake time memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wake_we) begin
            wake_mem[i_cmd.cur] <= i_cmd.wake_data;
        end
        if (issue) begin
            r_rd_data <= wake_mem[r_issue_t];
        end
    end

    // scan address and check pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_issue_t   <= next_task(i_cmd.cur);
            r_issue_cnt <= '0;
        end else if (issue) begin
            r_issue_t   <= next_task(r_issue_t);
            r_issue_cnt <= CNT_W'(r_issue_cnt + 1'b1);
        end
        if (issue) begin
            r_chk_t    <= r_issue_t;
            r_chk_last <= (r_issue_cnt == CNT_W'(NUM_TASKS - 1));
            r_rd_vld   <= r_wake_vld[r_issue_t];
        end
    end

    // scan control, blocked flags and wake valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_wake_vld <= '0;
            r_blocked  <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_active <= 1'b1;
            end else if (done) begin
                r_active <= 1'b0;
            end
            r_chk_vld <= issue && !done;
            if (i_cmd.wake_we) begin
                r_wake_vld[i_cmd.cur] <= 1'b1;
            end
            if (i_cmd.block_set) begin
                r_blocked[i_cmd.cur] <= 1'b1;
            end
            if (i_cmd.block_clr) begin
                r_blocked[i_cmd.clr_task] <= 1'b0;
            end
        end
    end

endmodule

[src/task_scheduler_semaphore_unit.sv]
// Task scheduler with counting semaphores.
// Request channel i_req carries mode, sem_index, sleep_ms and init_value; a word is
// taken when valid and ready are both high. Response channel o_rsp returns exactly
// one word per request: running task, no_ready, caller_blocked, released task and
// the semaphore count.
// A request is taken, then the semaphore entry is read in S_READ and updated in
// S_EXEC. Tick, init and out-of-range requests then go to S_DONE, a signal that
// releases a waiter passes S_RELEASE first. Sleep, reschedule and a blocking wait
// run the round-robin scan, which reads one wake-time entry per cycle from the task
// table memory until a ready task is found or every task has been checked.
// One request is in work at a time; the next is taken once the previous result
// sits in the output register.
// A stalled receiver holds the result in the output register; the block still
// takes and works on the next request and waits with its result until the output
// register is free.
// Reset (synchronous, active low) clears the running task, the tick counter, the
// blocked flags and the valid bits of the wake-time and semaphore tables, so all
// counts and wake times read as zero. The wait queue memory needs no clearing.
module task_scheduler_semaphore_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tssu_req_if.sink          i_req,
    tssu_rsp_if.source        o_rsp
);
    import tssu_pkg::*;

    t_state r_state, n_state;

    // latched request
    logic [2:0]  r_mode;
    logic [2:0]  r_sem_idx;
    logic [15:0] r_ms;
    logic [7:0]  r_initv;
    logic [15:0] r_q0;
    logic [15:0] r_quot;

    // scheduler state
    t_task             r_cur;
    logic [TICK_W-1:0] r_tick;

    // semaphore table
    t_sem_entry          sem_mem [NUM_SEMS];
    logic [NUM_SEMS-1:0] r_sem_vld;
    t_sem_entry          r_sem_rd;
    logic                r_sem_rd_vld;

    // wait queue memory
    t_task q_mem [Q_DEPTH];
    t_task r_q_rd;

    // result under construction
    logic                    r_no_ready;
    logic                    r_blk;
    logic                    r_rel_vld;
    t_task                   r_rel_task;
    logic signed [VAL_W-1:0] r_count;

    // output register
    logic                    r_out_vld;
    t_task                   r_out_cur;
    logic                    r_out_no_ready;
    logic                    r_out_blk;
    logic                    r_out_rel_vld;
    t_task                   r_out_rel_task;
    logic signed [VAL_W-1:0] r_out_count;

    logic                    accept;
    logic                    out_load;
    logic                    sem_ok;
    logic [SEM_AW-1:0]       sem_addr;
    t_sem_entry              sem_cur;
    logic signed [VAL_W-1:0] sem_dec;
    logic signed [VAL_W-1:0] sem_inc;
    logic [47:0]             div_prod;
    logic [31:0]             div_rem;
    logic [QA_W-1:0]         q_waddr;
    logic [QA_W-1:0]         q_raddr;

    logic                    sem_we;
    t_sem_entry              sem_wdata;
    logic                    q_we;
    logic                    q_re;
    logic                    tick_inc;
    logic                    cnt_en;
    logic signed [VAL_W-1:0] cnt_val;
    logic                    rel_req;
    t_tt_cmd                 tt_cmd;
    t_tt_sts                 tt_sts;

    tssu_task_table u_task_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tt_cmd),
        .o_sts   (tt_sts)
    );

    // handshakes
    assign accept   = i_req.valid && i_req.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.running_task   = 3'(r_out_cur);
    assign o_rsp.no_ready       = r_out_no_ready;
    assign o_rsp.caller_blocked = r_out_blk;
    assign o_rsp.released_valid = r_out_rel_vld;
    assign o_rsp.released_task  = 3'(r_out_rel_task);
    assign o_rsp.sem_count      = r_out_count;

    // ms to ticks: reciprocal multiply, one-step correction in the read cycle
    assign div_prod = 48'(i_req.sleep_ms) * 48'(DIV_RECIP);
    assign div_rem  = 32'(r_ms) - (32'(r_q0) * 32'(MS_PER_TICK));

    // semaphore entry and arithmetic
    assign sem_ok   = (32'(r_sem_idx) < 32'(NUM_SEMS));
    assign sem_addr = SEM_AW'({5'd0, r_sem_idx});
    assign sem_cur  = r_sem_rd_vld ? r_sem_rd : '0;
    assign sem_dec  = (sem_cur.value != SEM_MIN) ? sem_cur.value - 9'sd1 : sem_cur.value;
    assign sem_inc  = (sem_cur.value != SEM_MAX) ? sem_cur.value + 9'sd1 : sem_cur.value;
    assign q_waddr  = QA_W'(32'(sem_addr) * 32'(NUM_TASKS) + 32'(sem_cur.tail));
    assign q_raddr  = QA_W'(32'(sem_addr) * 32'(NUM_TASKS) + 32'(sem_cur.head));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (tt_cmd.scan_start) begin
                    n_state = S_SCAN;
                end else if (q_re) begin
                    n_state = S_RELEASE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RELEASE: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (tt_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // per-state actions
    always_comb begin
        sem_we             = 1'b0;
        sem_wdata          = sem_cur;
        q_we               = 1'b0;
        q_re               = 1'b0;
        tick_inc           = 1'b0;
        cnt_en             = 1'b0;
        cnt_val            = '0;
        rel_req            = 1'b0;
        tt_cmd             = '0;
        tt_cmd.cur         = r_cur;
        tt_cmd.clr_task    = r_q_rd;
        tt_cmd.tick        = r_tick;
        tt_cmd.wake_data   = r_tick + 32'(r_quot);
        case (r_state)
            S_EXEC: begin
                case (r_mode)
                    MODE_TICK: begin
                        tick_inc = 1'b1;
                    end
                    MODE_SLEEP: begin
                        tt_cmd.wake_we    = 1'b1;
                        tt_cmd.scan_start = 1'b1;
                    end
                    MODE_WAIT: begin
                        if (sem_ok) begin
                            sem_we          = 1'b1;
                            sem_wdata.value = sem_dec;
                            cnt_en          = 1'b1;
                            cnt_val         = sem_dec;
                            if (sem_dec < 0) begin
                                sem_wdata.tail    = next_task(sem_cur.tail);
                                q_we              = 1'b1;
                                tt_cmd.block_set  = 1'b1;
                                tt_cmd.scan_start = 1'b1;
                            end
                        end
                    end
                    MODE_SIGNAL: begin
                        if (sem_ok) begin
                            sem_we          = 1'b1;
                            sem_wdata.value = sem_inc;
                            cnt_en          = 1'b1;
                            cnt_val         = sem_inc;
                            if (sem_inc <= 0) begin
                                sem_wdata.head = next_task(sem_cur.head);
                                q_re           = 1'b1;
                            end
                        end
                    end
                    MODE_INIT: begin
                        if (sem_ok) begin
                            sem_we          = 1'b1;
                            sem_wdata.value = $signed({1'b0, r_initv});
                            sem_wdata.head  = '0;
                            sem_wdata.tail  = '0;
                            cnt_en          = 1'b1;
                            cnt_val         = $signed({1'b0, r_initv});
                        end
                    end
                    MODE_RESCHED: begin
                        tt_cmd.scan_start = 1'b1;
                    end
                    default: begin
                        cnt_en = 1'b0;
                    end
                endcase
            end
            S_RELEASE: begin
                tt_cmd.block_clr = 1'b1;
                rel_req          = 1'b1;
            end
            default: begin
                sem_we = 1'b0;
            end
        endcase
    end

    // semaphore and wait queue memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_sem_rd <= sem_mem[sem_addr];
        end
        if (sem_we) begin
            sem_mem[sem_addr] <= sem_wdata;
        end
        if (q_we) begin
            q_mem[q_waddr] <= r_cur;
        end
        if (q_re) begin
            r_q_rd <= q_mem[q_raddr];
        end
    end

    // request latch, quotient and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode     <= i_req.mode;
            r_sem_idx  <= i_req.sem_index;
            r_ms       <= i_req.sleep_ms;
            r_initv    <= i_req.init_value;
            r_q0       <= div_prod[47:32];
            r_blk      <= 1'b0;
            r_rel_vld  <= 1'b0;
            r_rel_task <= '0;
            r_count    <= '0;
            r_no_ready <= 1'b0;
        end
        if (r_state == S_READ) begin
            r_quot       <= (div_rem >= 32'(MS_PER_TICK)) ? 16'(r_q0 + 1'b1) : r_q0;
            r_sem_rd_vld <= r_sem_vld[sem_addr];
        end
        if (cnt_en) begin
            r_count <= cnt_val;
        end
        if (tt_cmd.block_set) begin
            r_blk <= 1'b1;
        end
        if (rel_req) begin
            r_rel_vld  <= 1'b1;
            r_rel_task <= r_q_rd;
        end
        if ((r_state == S_SCAN) && tt_sts.done && !tt_sts.found) begin
            r_no_ready <= 1'b1;
        end
        if (out_load) begin
            r_out_cur      <= r_cur;
            r_out_no_ready <= r_no_ready;
            r_out_blk      <= r_blk;
            r_out_rel_vld  <= r_rel_vld;
            r_out_rel_task <= r_rel_task;
            r_out_count    <= r_count;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_tick    <= '0;
            r_sem_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (tick_inc) begin
                r_tick <= r_tick + 32'd1;
            end
            if (sem_we) begin
                r_sem_vld[sem_addr] <= 1'b1;
            end
            if ((r_state == S_SCAN) && tt_sts.done && tt_sts.found) begin
                r_cur <= tt_sts.run_task;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule
